>>> sv/q24a_pkg.sv
// ---------------------------------------------------------------------------
// q24a_pkg
// Opcodes and the side-band bundle shared by the stages of the fixed-point ALU.
// ---------------------------------------------------------------------------
package q24a_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9
  } op_t;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  // Everything a request carries alongside the divider datapath
  typedef struct packed {
    logic [3:0]  op;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] res;
    logic        ov;
    logic [63:0] prod;
    logic        neg;
    logic        dz;
    logic        a_neg;
    logic        a_zero;
  } side_t;

endpackage

>>> sv/q24a_front.sv
// ---------------------------------------------------------------------------
// q24a_front
// First stage: flags, the ops that need no divider or rounding, the multiply and divider setup.
// ---------------------------------------------------------------------------
module q24a_front import q24a_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic [3:0]              op_i,
  input  logic signed [31:0]      a_i,
  input  logic signed [31:0]      b_i,
  output logic                    vld_r,
  output side_t                   side_r,
  output logic [32+FRAC_BITS-1:0] num_r,
  output logic [31:0]             den_r
);

  localparam int NW = 32 + FRAC_BITS;

  side_t            side_nxt;
  logic [32:0]      sum;
  logic [32:0]      dif;
  logic [31:0]      a_mag;
  logic [31:0]      b_mag;
  logic [31:0]      ti;
  logic [FRAC_BITS:0] hi;
  logic             lt_s;

  always_comb begin
    sum      = {a_i[31], a_i} + {b_i[31], b_i};
    dif      = {a_i[31], a_i} - {b_i[31], b_i};
    a_mag    = a_i[31] ? (32'd0 - a_i) : a_i;
    b_mag    = b_i[31] ? (32'd0 - b_i) : b_i;
    ti       = a_mag >> FRAC_BITS;
    hi       = a_i[31:31-FRAC_BITS];
    lt_s     = a_i < b_i;

    side_nxt        = '0;
    side_nxt.op     = op_i;
    side_nxt.gt     = !lt_s && (a_i != b_i);
    side_nxt.lt     = lt_s;
    side_nxt.eq     = a_i == b_i;
    side_nxt.prod   = 64'(a_i * b_i);
    side_nxt.neg    = a_i[31] ^ b_i[31];
    side_nxt.dz     = (op_i == OP_DIV) && (b_i == 32'sd0);
    side_nxt.a_neg  = a_i[31];
    side_nxt.a_zero = a_i == 32'sd0;

    // Resolve the operations that need neither the divider nor the back-end rounding
    case (op_t'(op_i))
      OP_ADD: begin
        side_nxt.ov  = sum[32] != sum[31];
        side_nxt.res = side_nxt.ov ? (sum[32] ? NEG_MIN : POS_MAX) : sum[31:0];
      end
      OP_SUB: begin
        side_nxt.ov  = dif[32] != dif[31];
        side_nxt.res = side_nxt.ov ? (dif[32] ? NEG_MIN : POS_MAX) : dif[31:0];
      end
      OP_MIN: side_nxt.res = lt_s ? a_i : b_i;
      OP_MAX: side_nxt.res = (!lt_s && (a_i != b_i)) ? a_i : b_i;
      OP_INC: begin
        side_nxt.ov  = a_i == POS_MAX;
        side_nxt.res = side_nxt.ov ? POS_MAX : a_i + 32'd1;
      end
      OP_DEC: begin
        side_nxt.ov  = a_i == NEG_MIN;
        side_nxt.res = side_nxt.ov ? NEG_MIN : a_i - 32'd1;
      end
      OP_FROM_INT: begin
        side_nxt.ov  = !((&hi) || !(|hi));
        side_nxt.res = side_nxt.ov ? (a_i[31] ? NEG_MIN : POS_MAX)
                                   : {a_i[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      end
      OP_TO_INT: side_nxt.res = a_i[31] ? (32'd0 - ti) : ti;
      default:   side_nxt.res = '0;
    endcase
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    num_r  <= {a_mag, {FRAC_BITS{1'b0}}};
    den_r  <= b_mag;
  end

  logic unused_nw;
  assign unused_nw = NW[0];

endmodule

>>> sv/q24a_div_stage.sv
// ---------------------------------------------------------------------------
// q24a_div_stage
// One restoring-division step: one quotient bit per stage.
// ---------------------------------------------------------------------------
module q24a_div_stage import q24a_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  side_t                   side_i,
  input  logic [32+FRAC_BITS-1:0] num_i,
  input  logic [31:0]             den_i,
  input  logic [31:0]             rem_i,
  input  logic [32+FRAC_BITS-1:0] quo_i,
  output logic                    vld_r,
  output side_t                   side_r,
  output logic [32+FRAC_BITS-1:0] num_r,
  output logic [31:0]             den_r,
  output logic [31:0]             rem_r,
  output logic [32+FRAC_BITS-1:0] quo_r
);

  localparam int NW = 32 + FRAC_BITS;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    ge    = trial >= {1'b0, den_i};
    diff  = trial - {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    den_r  <= den_i;
    num_r  <= {num_i[NW-2:0], 1'b0};
    rem_r  <= ge ? diff[31:0] : trial[31:0];
    quo_r  <= {quo_i[NW-2:0], ge};
  end

endmodule

>>> sv/q24a_back.sv
// ---------------------------------------------------------------------------
// q24a_back
// Last stage: round product and quotient, saturate, pick the result.
// ---------------------------------------------------------------------------
module q24a_back import q24a_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  side_t                   side_i,
  input  logic [31:0]             den_i,
  input  logic [31:0]             rem_i,
  input  logic [32+FRAC_BITS-1:0] quo_i,
  output logic                    vld_r,
  output logic [31:0]             res_r,
  output logic                    gt_r,
  output logic                    lt_r,
  output logic                    eq_r,
  output logic                    ov_r,
  output logic                    dz_r
);

  localparam int NW = 32 + FRAC_BITS;

  // Saturate a sign and magnitude into 32 bits; bit 32 is the overflow
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, NEG_MIN};
      else                     r = {1'b0, 32'd0 - mag[31:0]};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, POS_MAX};
      else                     r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  logic [63:0] pmag;
  logic [63:0] mrnd;
  logic [NW:0] qrnd;
  logic        up;
  logic [32:0] mul_s;
  logic [32:0] div_s;
  logic [31:0] res_nxt;
  logic        ov_nxt;

  always_comb begin
    pmag  = side_i.prod[63] ? (64'd0 - side_i.prod) : side_i.prod;
    mrnd  = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    up    = {rem_i, 1'b0} >= {1'b0, den_i};
    qrnd  = {1'b0, quo_i} + {{NW{1'b0}}, up};
    mul_s = sat_mag(side_i.prod[63], mrnd);
    div_s = sat_mag(side_i.neg, 64'(qrnd));

    res_nxt = side_i.res;
    ov_nxt  = side_i.ov;
    case (op_t'(side_i.op))
      OP_MUL: begin
        res_nxt = mul_s[31:0];
        ov_nxt  = mul_s[32];
      end
      OP_DIV: begin
        if (side_i.dz) begin
          res_nxt = side_i.a_zero ? 32'd0 : (side_i.a_neg ? NEG_MIN : POS_MAX);
          ov_nxt  = !side_i.a_zero;
        end else begin
          res_nxt = div_s[31:0];
          ov_nxt  = div_s[32];
        end
      end
      default: begin
        res_nxt = side_i.res;
        ov_nxt  = side_i.ov;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    ov_r  <= ov_nxt;
    gt_r  <= side_i.gt;
    lt_r  <= side_i.lt;
    eq_r  <= side_i.eq;
    dz_r  <= side_i.dz;
  end

endmodule

>>> sv/q24_8_fixed_point_alu.sv
// ---------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Pipelined signed fixed-point ALU with compare, overflow and divide flags.
// ---------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy stays low. Each
// result passes through the front stage, the divider stages and the back
// stage and leaves one per cycle, in request order, with out_valid high
// for one cycle. The divider resolves one quotient bit per stage over
// 32 + FRAC_BITS stages, and every other operation rides the same pipe
// alongside it. The receiver cannot stall, so results must be captured on
// the cycle they are shown.
module q24_8_fixed_point_alu import q24a_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] in_b,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic               out_a_greater,
  output logic               out_a_less,
  output logic               out_a_equal,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  localparam int NW = 32 + FRAC_BITS;

  logic          vld  [NW+1];
  side_t         side [NW+1];
  logic [NW-1:0] num  [NW+1];
  logic [31:0]   den  [NW+1];
  logic [31:0]   rem  [NW+1];
  logic [NW-1:0] quo  [NW+1];

  assign busy   = 1'b0;
  assign rem[0] = '0;
  assign quo[0] = '0;

  // Decode, flag and set up the divider
  q24a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start && !busy),
    .op_i   (in_op),
    .a_i    (in_a),
    .b_i    (in_b),
    .vld_r  (vld[0]),
    .side_r (side[0]),
    .num_r  (num[0]),
    .den_r  (den[0])
  );

  // Divider steps, one quotient bit each
  for (genvar k = 0; k < NW; k++) begin : g_div
    q24a_div_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld[k]),
      .side_i (side[k]),
      .num_i  (num[k]),
      .den_i  (den[k]),
      .rem_i  (rem[k]),
      .quo_i  (quo[k]),
      .vld_r  (vld[k+1]),
      .side_r (side[k+1]),
      .num_r  (num[k+1]),
      .den_r  (den[k+1]),
      .rem_r  (rem[k+1]),
      .quo_r  (quo[k+1])
    );
  end

  // Round, saturate and register the result
  q24a_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld[NW]),
    .side_i (side[NW]),
    .den_i  (den[NW]),
    .rem_i  (rem[NW]),
    .quo_i  (quo[NW]),
    .vld_r  (out_valid),
    .res_r  (out_result),
    .gt_r   (out_a_greater),
    .lt_r   (out_a_less),
    .eq_r   (out_a_equal),
    .ov_r   (out_overflow),
    .dz_r   (out_divide_by_zero)
  );

  logic unused_num;
  assign unused_num = ^num[NW];

endmodule
